// ===== rtl/core/memory_pressure_monitor_defines.svh =====
// Assertion helpers for the memory pressure monitor.
`ifndef MEMORY_PRESSURE_MONITOR_DEFINES_SVH
`define MEMORY_PRESSURE_MONITOR_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MPM_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define MPM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/mpm_pkg.sv =====
package mpm_pkg;

	localparam int unsigned BYTES_W  = 48;
	localparam int unsigned LEVEL_W  = 16;
	localparam int unsigned PERIOD_W = 8;
	localparam int unsigned PROD_W   = BYTES_W + LEVEL_W;
	localparam int unsigned CFG_W    = 16;

	// Request kinds
	localparam logic ACT_ALLOC = 1'b0;
	localparam logic ACT_HEAP  = 1'b1;

	// Configuration register indexes
	localparam logic [1:0] CFG_SAMPLE_PERIOD  = 2'd0;
	localparam logic [1:0] CFG_ELEVATED_LEVEL = 2'd1;
	localparam logic [1:0] CFG_CRITICAL_LEVEL = 2'd2;
	localparam logic [1:0] CFG_RECOVERY_LEVEL = 2'd3;

	// Reset values of the configuration registers (Q0.16 for the levels)
	localparam logic [PERIOD_W-1:0] RST_SAMPLE_PERIOD  = 8'd32;
	localparam logic [LEVEL_W-1:0]  RST_ELEVATED_LEVEL = 16'd53740;
	localparam logic [LEVEL_W-1:0]  RST_CRITICAL_LEVEL = 16'd60293;
	localparam logic [LEVEL_W-1:0]  RST_RECOVERY_LEVEL = 16'd48497;

	typedef enum logic [1:0] {
		LVL_NORMAL   = 2'd0,
		LVL_ELEVATED = 2'd1,
		LVL_CRITICAL = 2'd2
	} level_t;

endpackage

// ===== rtl/core/memory_pressure_monitor.sv =====
// Memory pressure monitor.
// Input channel (in_valid / in_stall) takes one request per cycle unless
// stalled: an allocation event (action 0) or a heap report (action 1) carrying
// usage, budget and capacity; last_heap marks the report that closes a sample.
// Output channel (out_valid / out_stall) returns exactly one result per
// request, in order: pressure state, strategy hint, sample_due, allocation
// total and peak usage as they stand after that request.
// A request taken passes through stage 1 into the result register, which
// raises out_valid; while the result is stalled, the request waits in stage 1.
// Throughput is one request per cycle while out_stall stays low: the three
// level*budget products are formed on the way into stage 1, the compares
// and the state update sit between stage 1 and the result register.
// When the receiver stalls, the result holds; one more request can sit in
// stage 1, after which in_stall rises until the result is taken.
// Reset clears all counters, flags, the peak and the hysteresis state
// (normal) and restores the default period (32) and thresholds.
// Configuration writes (cfg_we, cfg_index, cfg_data) take effect at once
// and belong in idle periods only.
`include "memory_pressure_monitor_defines.svh"

module memory_pressure_monitor (
	input  logic                          clk,
	input  logic                          arst_n,
	// configuration
	input  logic                          cfg_we,
	input  logic [1:0]                    cfg_index,
	input  logic [mpm_pkg::CFG_W-1:0]     cfg_data,
	// request channel
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          action,
	input  logic [mpm_pkg::BYTES_W-1:0]   heap_usage,
	input  logic [mpm_pkg::BYTES_W-1:0]   heap_budget,
	input  logic [mpm_pkg::BYTES_W-1:0]   heap_capacity,
	input  logic                          last_heap,
	// result channel
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [1:0]                    pressure_state,
	output logic                          min_memory_strategy,
	output logic                          sample_due,
	output logic [mpm_pkg::BYTES_W-1:0]   total_allocations,
	output logic [mpm_pkg::BYTES_W-1:0]   peak_bytes
);
	import mpm_pkg::*;

	// configuration registers
	logic [PERIOD_W-1:0] sample_period_q;
	logic [LEVEL_W-1:0]  elevated_level_q;
	logic [LEVEL_W-1:0]  critical_level_q;
	logic [LEVEL_W-1:0]  recovery_level_q;

	// stage 1: request plus threshold products
	logic                v_s1;
	logic                action_s1;
	logic                last_s1;
	logic                usable_s1;
	logic [BYTES_W-1:0]  usage_s1;
	logic [PROD_W-1:0]   prod_elev_s1;
	logic [PROD_W-1:0]   prod_crit_s1;
	logic [PROD_W-1:0]   prod_rec_s1;

	// architectural state; also serves as the result register
	logic                out_valid_q;
	logic                sample_due_q;
	logic [PERIOD_W-1:0] since_q;
	logic [BYTES_W-1:0]  total_q;
	level_t              level_q;
	logic [BYTES_W-1:0]  peak_q;
	logic [BYTES_W-1:0]  max_q;
	logic                seen_elev_q;
	logic                seen_crit_q;
	logic                seen_rec_q;

	// next-state values
	logic                sample_due_n;
	logic [PERIOD_W-1:0] since_n;
	logic [PERIOD_W-1:0] since_inc;
	logic [BYTES_W-1:0]  total_n;
	level_t              level_n;
	logic [BYTES_W-1:0]  peak_n;
	logic [BYTES_W-1:0]  max_n;
	logic                seen_elev_n;
	logic                seen_crit_n;
	logic                seen_rec_n;

	// handshake
	logic                out_ready;
	logic                s1_ready;
	logic                accept;
	logic                commit;

	// stage 1 datapath
	logic [BYTES_W-1:0]  budget_sel;
	logic                usable_d;

	// stage 2 compares
	logic [PROD_W-1:0]   usage_scaled;
	logic                hit_elev;
	logic                hit_crit;
	logic                hit_rec;
	logic                ge_elev;
	logic                ge_crit;
	logic                ge_rec;

	// run values including the heap in stage 1
	logic [BYTES_W-1:0]  max_run;
	logic                seen_elev_run;
	logic                seen_crit_run;
	logic                seen_rec_run;

	// result fields packed for the hold check
	logic [2*BYTES_W+3:0] result_w;

	// ------------------------------------------------------------------
	// Flow control: the result register frees when empty or when taken,
	// stage 1 frees when empty or when it drains into the result register.
	// ------------------------------------------------------------------
	assign out_ready = !out_valid_q || !out_stall;
	assign s1_ready  = !v_s1 || out_ready;
	assign in_stall  = !s1_ready;
	assign accept    = in_valid && s1_ready;
	assign commit    = v_s1 && out_ready;

	// ------------------------------------------------------------------
	// Configuration registers
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_period_q  <= RST_SAMPLE_PERIOD;
			elevated_level_q <= RST_ELEVATED_LEVEL;
			critical_level_q <= RST_CRITICAL_LEVEL;
			recovery_level_q <= RST_RECOVERY_LEVEL;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_SAMPLE_PERIOD:  sample_period_q  <= cfg_data[PERIOD_W-1:0];
				CFG_ELEVATED_LEVEL: elevated_level_q <= cfg_data[LEVEL_W-1:0];
				CFG_CRITICAL_LEVEL: critical_level_q <= cfg_data[LEVEL_W-1:0];
				CFG_RECOVERY_LEVEL: recovery_level_q <= cfg_data[LEVEL_W-1:0];
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Stage 1: pick the effective budget (capacity when the budget is
	// unknown) and form level * budget for each threshold. The ratio test
	// usage / budget >= level / 2^16 becomes usage * 2^16 >= level * budget.
	// ------------------------------------------------------------------
	assign budget_sel = (heap_budget != '0) ? heap_budget : heap_capacity;
	assign usable_d   = (budget_sel != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s1_ready) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			action_s1    <= action;
			last_s1      <= last_heap;
			usable_s1    <= usable_d;
			usage_s1     <= heap_usage;
			prod_elev_s1 <= {{BYTES_W{1'b0}}, elevated_level_q} * {{LEVEL_W{1'b0}}, budget_sel};
			prod_crit_s1 <= {{BYTES_W{1'b0}}, critical_level_q} * {{LEVEL_W{1'b0}}, budget_sel};
			prod_rec_s1  <= {{BYTES_W{1'b0}}, recovery_level_q} * {{LEVEL_W{1'b0}}, budget_sel};
		end
	end

	// ------------------------------------------------------------------
	// Stage 2: threshold compares and this heap's contribution to the run
	// ------------------------------------------------------------------
	assign usage_scaled = {usage_s1, {LEVEL_W{1'b0}}};
	assign hit_elev     = usable_s1 && (usage_scaled >= prod_elev_s1);
	assign hit_crit     = usable_s1 && (usage_scaled >= prod_crit_s1);
	assign hit_rec      = usable_s1 && (usage_scaled >= prod_rec_s1);

	// Fold the heap into the run; a skipped heap leaves the run untouched.
	assign max_run       = (usable_s1 && (usage_s1 > max_q)) ? usage_s1 : max_q;
	assign seen_elev_run = seen_elev_q || hit_elev;
	assign seen_crit_run = seen_crit_q || hit_crit;
	assign seen_rec_run  = seen_rec_q || hit_rec;

	// A zero level counts as reached even when no heap of the run was usable.
	assign ge_elev = seen_elev_run || (elevated_level_q == '0);
	assign ge_crit = seen_crit_run || (critical_level_q == '0);
	assign ge_rec  = seen_rec_run || (recovery_level_q == '0);

	assign since_inc = since_q + PERIOD_W'(1);

	always_comb begin
		sample_due_n = 1'b0;
		since_n      = since_q;
		total_n      = total_q;
		level_n      = level_q;
		peak_n       = peak_q;
		max_n        = max_q;
		seen_elev_n  = seen_elev_q;
		seen_crit_n  = seen_crit_q;
		seen_rec_n   = seen_rec_q;
		if (action_s1 == ACT_ALLOC) begin
			// advance the counters; >= fires at once on a lowered period
			total_n = total_q + BYTES_W'(1);
			if (since_inc >= sample_period_q) begin
				since_n      = '0;
				sample_due_n = 1'b1;
			end else begin
				since_n = since_inc;
			end
		end else begin
			max_n       = max_run;
			seen_elev_n = seen_elev_run;
			seen_crit_n = seen_crit_run;
			seen_rec_n  = seen_rec_run;
			if (last_s1) begin
				// close the run: update peak and hysteresis, drop the flags
				if (max_run > peak_q)
					peak_n = max_run;
				case (level_q)
					LVL_ELEVATED: begin
						if (ge_crit)
							level_n = LVL_CRITICAL;
						else if (!ge_rec)
							level_n = LVL_NORMAL;
					end
					LVL_CRITICAL: begin
						if (!ge_rec)
							level_n = LVL_NORMAL;
						else if (!ge_elev)
							level_n = LVL_ELEVATED;
					end
					default: begin
						if (ge_crit)
							level_n = LVL_CRITICAL;
						else if (ge_elev)
							level_n = LVL_ELEVATED;
						else
							level_n = LVL_NORMAL;
					end
				endcase
				max_n       = '0;
				seen_elev_n = 1'b0;
				seen_crit_n = 1'b0;
				seen_rec_n  = 1'b0;
			end
		end
	end

	// Advance the state only when stage 1 drains; hold it while stalled.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			sample_due_q <= 1'b0;
			since_q      <= '0;
			total_q      <= '0;
			level_q      <= LVL_NORMAL;
			peak_q       <= '0;
			max_q        <= '0;
			seen_elev_q  <= 1'b0;
			seen_crit_q  <= 1'b0;
			seen_rec_q   <= 1'b0;
		end else if (commit) begin
			out_valid_q  <= 1'b1;
			sample_due_q <= sample_due_n;
			since_q      <= since_n;
			total_q      <= total_n;
			level_q      <= level_n;
			peak_q       <= peak_n;
			max_q        <= max_n;
			seen_elev_q  <= seen_elev_n;
			seen_crit_q  <= seen_crit_n;
			seen_rec_q   <= seen_rec_n;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid           = out_valid_q;
	assign pressure_state      = level_q;
	assign min_memory_strategy = (level_q == LVL_CRITICAL);
	assign sample_due          = sample_due_q;
	assign total_allocations   = total_q;
	assign peak_bytes          = peak_q;

	assign result_w = {pressure_state, min_memory_strategy, sample_due, total_allocations,
		peak_bytes};

	`MPM_ASSERT_NEXT(a_result_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(result_w), "result changed while stalled")
	`MPM_ASSERT_SAME(a_strategy, clk, arst_n, 1'b1, min_memory_strategy == (level_q == LVL_CRITICAL), "strategy disagrees with state")
	`MPM_ASSERT_SAME(a_level_legal, clk, arst_n, 1'b1, (level_q == LVL_NORMAL) || (level_q == LVL_ELEVATED) || (level_q == LVL_CRITICAL), "illegal pressure state")
	`MPM_ASSERT_SAME(a_full_stalls, clk, arst_n, v_s1 && out_valid_q && out_stall, in_stall, "request taken while full")

endmodule
